@@ src/lslf_pkg.sv @@
`timescale 1ns / 1ps

package lslf_pkg;

  // Set size and coordinate format
  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 8;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Running sums
  localparam int SUM_W = COORD_W + CNT_W;
  localparam int SQ_W  = 2 * COORD_W - 1 + CNT_W;
  localparam int SPLIT = SQ_W / 2;

  // Fit arithmetic
  localparam int NUM_W = 2 * CNT_W + 2 * COORD_W;
  localparam int RES_W = 32;
  localparam int FRAC_W = 16;
  localparam int T_W   = RES_W + 1 + SUM_W;

  // Shared multiplier operand widths
  localparam int MB_W = SUM_W + 1;
  localparam int MA_W = (SUM_W + 1 > RES_W) ? SUM_W + 1 : RES_W;
  localparam int P_W  = MA_W + MB_W;

  // Shared divider: quotient bits, divisor width, step counter
  localparam int QB       = 34;
  localparam int SLOPE_SH = QB - (FRAC_W + 1);
  localparam int DVS_W    = NUM_W;
  localparam int QCNT_W   = $clog2(QB);
  localparam int MAG_W    = QB + 1;

  localparam logic [RES_W-1:0] Q_MAX = {1'b0, {(RES_W - 1){1'b1}}};
  localparam logic [RES_W-1:0] Q_MIN = {1'b1, {(RES_W - 1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_HALF = MAG_W'(1) << (RES_W - 1);

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // Apply sign to a magnitude and clamp to the signed result range
  function automatic logic [RES_W-1:0] sat_q16(input logic neg, input logic ovf,
                                               input logic [MAG_W-1:0] mag);
    logic [RES_W-1:0] r;
    if (neg) begin
      if (ovf || (mag >= MAG_HALF)) r = Q_MIN;
      else r = -mag[RES_W-1:0];
    end else begin
      if (ovf || (mag >= MAG_HALF)) r = Q_MAX;
      else r = mag[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/lslf_mul.sv @@
`timescale 1ns / 1ps

module lslf_mul import lslf_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [MA_W-1:0] a_i,
  input  logic signed [MB_W-1:0] b_i,
  output logic signed [P_W-1:0]  prod_o
);

  logic signed [P_W-1:0] prod_q;

  // Register every product; the sequencer picks it up in the following cycle
  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(a_i) * P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ src/lslf_div.sv @@
`timescale 1ns / 1ps

module lslf_div import lslf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVS_W-1:0] hi_i,
  input  logic [QB-1:0]    lo_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic [QB-1:0]    quot_o,
  output logic [DVS_W-1:0] rem_o,
  output div_stat_t        stat_o
);

  logic [DVS_W-1:0]  rem_q;
  logic [QB-1:0]     shf_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              ovf_q;

  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  // One restoring step: bring down the next dividend bit and try the subtract
  assign trial = {rem_q, shf_q[QB-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      shf_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // Load high part as partial remainder; quotient too wide if it is not below the divisor
        rem_q  <= hi_i;
        shf_q  <= lo_i;
        dvs_q  <= dvs_i;
        ovf_q  <= hi_i >= dvs_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        shf_q <= {shf_q[QB-2:0], fits};
        cnt_q <= cnt_q + QCNT_W'(1);
        if (cnt_q == QCNT_W'(QB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o      = shf_q;
  assign rem_o       = rem_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

@@ src/least_squares_line_fit.sv @@
`timescale 1ns / 1ps

// Least-squares line fit over a stream of Q7.8 points.
// Input channel: in_valid_i / in_stall_o with in_item_i (x, y, last mark). A transfer
// takes place when valid is high and stall is low. Each point passes through the
// states PT_XY, PT_XX and PT_ACC, with two passes through the shared multiplier (x*y,
// then x*x); a point dropped because the set is full leaves after PT_XY.
// Output channel: out_valid_o / out_stall_i with out_item_o (slope, intercept, status).
// One result follows each point marked last: after the point is taken in, the shared
// multiplier forms the products in the states NXY_LO through DEN, one denominator check
// follows, then two 34-step divisions on the radix-2 divider, with the intercept term
// formed in SMUL, TERM and ISTART between them. A zero or negative denominator skips
// both divisions and gives the result straight from the check.
// The block takes no point while a fit runs or a result waits; while the receiver
// stalls, the result and its valid hold. The transfer of the result clears all sums
// and the point count for the next set.
// Reset clears the sums, the count and the dropped-point flag; the block is then
// ready at once.

module least_squares_line_fit import lslf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PT_XY,
    ST_PT_XX,
    ST_PT_ACC,
    ST_NXY_LO,
    ST_NXY_HI,
    ST_SXSY,
    ST_NUM,
    ST_NXX_LO,
    ST_NXX_HI,
    ST_SXSX,
    ST_DEN,
    ST_CHK,
    ST_SDIV,
    ST_SMUL,
    ST_TERM,
    ST_ISTART,
    ST_IDIV,
    ST_OUT
  } state_e;

  state_e state_q;

  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic                      last_q;
  logic [CNT_W-1:0]          count_q;
  logic signed [SUM_W-1:0]   sum_x_q;
  logic signed [SUM_W-1:0]   sum_y_q;
  logic signed [SQ_W-1:0]    sum_xy_q;
  logic signed [SQ_W-1:0]    sum_xx_q;
  logic                      drop_q;
  logic signed [NUM_W-1:0]   acc_q;
  logic signed [NUM_W-1:0]   num_q;
  logic signed [NUM_W-1:0]   den_q;
  logic signed [T_W-1:0]     t_q;
  logic signed [RES_W-1:0]   slope_q;
  logic signed [RES_W-1:0]   icept_q;
  logic [1:0]                status_q;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod;
  logic signed [MA_W-1:0] n_ext;

  logic             div_start;
  logic [DVS_W-1:0] div_hi;
  logic [QB-1:0]    div_lo;
  logic [DVS_W-1:0] div_dvs;
  logic [QB-1:0]    div_quot;
  logic [DVS_W-1:0] div_rem;
  div_stat_t        div_stat;

  logic [NUM_W-1:0]      num_mag;
  logic [T_W-1:0]        t_mag;
  logic [DVS_W-1:0]      icept_dvs;
  logic                  den_ok;
  logic                  icept_rnd;
  logic [MAG_W-1:0]      slope_mag;
  logic [MAG_W-1:0]      icept_mag;
  logic signed [T_W-1:0] sy_sh;

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign out_item_o  = '{slope: slope_q, intercept: icept_q, status: status_q};

  // Shared multiplier and its operand select
  assign n_ext = MA_W'({1'b0, count_q});

  always_comb begin
    mul_a = MA_W'(x_q);
    mul_b = MB_W'(y_q);
    unique case (state_q)
      ST_PT_XX: begin
        mul_b = MB_W'(x_q);
      end
      ST_NXY_LO: begin
        mul_a = n_ext;
        mul_b = MB_W'({1'b0, sum_xy_q[SPLIT-1:0]});
      end
      ST_NXY_HI: begin
        mul_a = n_ext;
        mul_b = MB_W'($signed(sum_xy_q[SQ_W-1:SPLIT]));
      end
      ST_SXSY: begin
        mul_a = MA_W'(sum_x_q);
        mul_b = MB_W'(sum_y_q);
      end
      ST_NXX_LO: begin
        mul_a = n_ext;
        mul_b = MB_W'({1'b0, sum_xx_q[SPLIT-1:0]});
      end
      ST_NXX_HI: begin
        mul_a = n_ext;
        mul_b = MB_W'($signed(sum_xx_q[SQ_W-1:SPLIT]));
      end
      ST_SXSX: begin
        mul_a = MA_W'(sum_x_q);
        mul_b = MB_W'(sum_x_q);
      end
      ST_SMUL: begin
        mul_a = MA_W'(slope_q);
        mul_b = MB_W'(sum_x_q);
      end
      default: begin
        mul_a = MA_W'(x_q);
        mul_b = MB_W'(y_q);
      end
    endcase
  end

  lslf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Divider operands: slope as |num| * 2^17 / den, intercept as |t| / (n * 2^8)
  assign num_mag   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign t_mag     = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
  assign icept_dvs = DVS_W'({count_q, {COORD_FRAC{1'b0}}});
  assign den_ok    = (den_q != '0) && !den_q[NUM_W-1];

  always_comb begin
    if (state_q == ST_ISTART) begin
      div_hi  = DVS_W'(t_mag[T_W-1:QB]);
      div_lo  = t_mag[QB-1:0];
      div_dvs = icept_dvs;
    end else begin
      div_hi  = DVS_W'(num_mag[NUM_W-1:SLOPE_SH]);
      div_lo  = {num_mag[SLOPE_SH-1:0], {(QB - SLOPE_SH){1'b0}}};
      div_dvs = DVS_W'(den_q);
    end
  end

  assign div_start = ((state_q == ST_CHK) && den_ok) || (state_q == ST_ISTART);

  lslf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .dvs_i   (div_dvs),
    .quot_o  (div_quot),
    .rem_o   (div_rem),
    .stat_o  (div_stat)
  );

  // Round the quotients: slope drops its extra fraction bit, intercept rounds on remainder
  assign slope_mag = MAG_W'((MAG_W'(div_quot) + MAG_W'(1)) >> 1);
  assign icept_rnd = {div_rem, 1'b0} >= {1'b0, icept_dvs};
  assign icept_mag = MAG_W'(div_quot) + MAG_W'(icept_rnd);
  assign sy_sh     = {{(T_W - SUM_W - FRAC_W){sum_y_q[SUM_W-1]}}, sum_y_q, {FRAC_W{1'b0}}};

  // Sequencer: state, sums and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      x_q      <= '0;
      y_q      <= '0;
      last_q   <= 1'b0;
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xy_q <= '0;
      sum_xx_q <= '0;
      drop_q   <= 1'b0;
      acc_q    <= '0;
      num_q    <= '0;
      den_q    <= '0;
      t_q      <= '0;
      slope_q  <= '0;
      icept_q  <= '0;
      status_q <= STATUS_OK;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          // Capture the point on transfer
          if (in_valid_i) begin
            x_q     <= in_item_i.point_x;
            y_q     <= in_item_i.point_y;
            last_q  <= in_item_i.last_point;
            state_q <= ST_PT_XY;
          end
        end
        ST_PT_XY: begin
          // Drop the point once the set is full
          if (count_q == CNT_W'(MAX_POINTS)) begin
            drop_q  <= 1'b1;
            state_q <= last_q ? ST_NXY_LO : ST_IDLE;
          end else begin
            state_q <= ST_PT_XX;
          end
        end
        ST_PT_XX: begin
          sum_xy_q <= sum_xy_q + SQ_W'(prod);
          state_q  <= ST_PT_ACC;
        end
        ST_PT_ACC: begin
          sum_xx_q <= sum_xx_q + SQ_W'(prod);
          sum_x_q  <= sum_x_q + SUM_W'(x_q);
          sum_y_q  <= sum_y_q + SUM_W'(y_q);
          count_q  <= count_q + CNT_W'(1);
          state_q  <= last_q ? ST_NXY_LO : ST_IDLE;
        end
        ST_NXY_LO: begin
          state_q <= ST_NXY_HI;
        end
        ST_NXY_HI: begin
          acc_q   <= NUM_W'(prod);
          state_q <= ST_SXSY;
        end
        ST_SXSY: begin
          acc_q   <= acc_q + {prod[NUM_W-SPLIT-1:0], {SPLIT{1'b0}}};
          state_q <= ST_NUM;
        end
        ST_NUM: begin
          num_q   <= acc_q - NUM_W'(prod);
          state_q <= ST_NXX_LO;
        end
        ST_NXX_LO: begin
          state_q <= ST_NXX_HI;
        end
        ST_NXX_HI: begin
          acc_q   <= NUM_W'(prod);
          state_q <= ST_SXSX;
        end
        ST_SXSX: begin
          acc_q   <= acc_q + {prod[NUM_W-SPLIT-1:0], {SPLIT{1'b0}}};
          state_q <= ST_DEN;
        end
        ST_DEN: begin
          den_q   <= acc_q - NUM_W'(prod);
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          // Degenerate set: no division, zero result
          if (den_ok) begin
            state_q <= ST_SDIV;
          end else begin
            slope_q  <= '0;
            icept_q  <= '0;
            status_q <= STATUS_DEGEN;
            state_q  <= ST_OUT;
          end
        end
        ST_SDIV: begin
          if (div_stat.done) begin
            slope_q <= sat_q16(num_q[NUM_W-1], div_stat.ovf, slope_mag);
            state_q <= ST_SMUL;
          end
        end
        ST_SMUL: begin
          state_q <= ST_TERM;
        end
        ST_TERM: begin
          t_q     <= sy_sh - T_W'(prod);
          state_q <= ST_ISTART;
        end
        ST_ISTART: begin
          state_q <= ST_IDIV;
        end
        ST_IDIV: begin
          if (div_stat.done) begin
            icept_q  <= sat_q16(t_q[T_W-1], div_stat.ovf, icept_mag);
            status_q <= drop_q ? STATUS_DROP : STATUS_OK;
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the result until its transfer, then clear the set
          if (!out_stall_i) begin
            count_q  <= '0;
            sum_x_q  <= '0;
            sum_y_q  <= '0;
            sum_xy_q <= '0;
            sum_xx_q <= '0;
            drop_q   <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/lslf_checker.sv @@
`timescale 1ns / 1ps

module lslf_checker import lslf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A waiting result blocks new points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("point channel open while a result waits");

  // Every point transfer leaves the block stalled in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready right after a point transfer");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // Result transfer returns the block to ready with no result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (!out_valid_o && !in_stall_o))
    else $error("block not ready after result transfer");

  // Degenerate fit carries a zero line and a defined status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.status == STATUS_OK) || (out_item_o.status == STATUS_DROP) ||
                     ((out_item_o.status == STATUS_DEGEN) && (out_item_o.slope == '0) &&
                      (out_item_o.intercept == '0))))
    else $error("bad status or nonzero degenerate result");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);

@@ sim/lslf_fit_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the line-fit block, predicts each fit from the accepted
// points and compares every returned fit against the oldest prediction.
module lslf_fit_checker import lslf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        mismatch_count_o,
  output int        pending_o,
  output int        fits_o,
  output int        degen_o,
  output int        drop_o
);

  // Keep the printout bounded when the block is badly off
  localparam int PRINT_CAP = 100;

  // Running state of the current set
  int unsigned set_points;
  longint      sum_px;
  longint      sum_py;
  longint      sum_pxy;
  longint      sum_pxx;
  bit          drop_pending;

  out_item_t   expected_fits[$];

  // Apply sign and clamp a magnitude to the Q15.16 range
  function automatic logic [31:0] clamp_q16(bit neg, logic [127:0] mag);
    if (neg) begin
      if (mag >= 128'h8000_0000) return Q_MIN;
      return -mag[31:0];
    end
    if (mag > 128'h7FFF_FFFF) return Q_MAX;
    return mag[31:0];
  endfunction

  // Slope: num / den scaled by 2^16, rounded half away from zero
  function automatic logic [31:0] fit_slope(longint num, longint den);
    logic [63:0]  an;
    logic [127:0] q;
    an = (num < 0) ? -num : num;
    q = ({64'd0, an} << 17) / {64'd0, den};
    q = (q + 128'd1) >> 1;
    return clamp_q16(num < 0, q);
  endfunction

  // Intercept: (Sy*2^16 - slope*Sx) / (n*2^8), using the clamped slope
  function automatic logic [31:0] fit_intercept(longint sy, longint sx,
                                                logic signed [31:0] slope, longint n);
    longint      sl;
    longint      t;
    logic [63:0] mag;
    logic [63:0] dv;
    logic [63:0] q;
    logic [63:0] rem;
    sl = slope;
    t = sy * 65536 - sl * sx;
    mag = (t < 0) ? -t : t;
    dv = n * 256;
    q = mag / dv;
    rem = mag % dv;
    if (rem >= dv - rem) q = q + 64'd1;
    return clamp_q16(t < 0, {64'd0, q});
  endfunction

  task automatic clear_set();
    set_points = 0;
    sum_px = 0;
    sum_py = 0;
    sum_pxy = 0;
    sum_pxx = 0;
    drop_pending = 1'b0;
  endtask

  // Accumulate one point; on the last point of a set queue the predicted fit
  task automatic take_point(in_item_t p);
    longint    px;
    longint    py;
    longint    n;
    longint    num;
    longint    den;
    out_item_t fit;
    px = $signed(p.point_x);
    py = $signed(p.point_y);
    if (set_points < MAX_POINTS) begin
      set_points++;
      sum_px += px;
      sum_py += py;
      sum_pxy += px * py;
      sum_pxx += px * px;
    end else begin
      drop_pending = 1'b1;
    end
    if (!p.last_point) return;

    n = set_points;
    num = n * sum_pxy - sum_px * sum_py;
    den = n * sum_pxx - sum_px * sum_px;
    if (den <= 0 || n == 0) begin
      fit.slope = '0;
      fit.intercept = '0;
      fit.status = STATUS_DEGEN;
    end else begin
      fit.slope = fit_slope(num, den);
      fit.intercept = fit_intercept(sum_py, sum_px, fit.slope, n);
      fit.status = drop_pending ? STATUS_DROP : STATUS_OK;
    end
    expected_fits.push_back(fit);
    pending_o = expected_fits.size();
    clear_set();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count_o < PRINT_CAP)
      $display("%0t: fit %0d %s mismatch: got %08h, expected %08h",
               $realtime, fits_o, what, got, want);
    mismatch_count_o++;
  endtask

  // Compare a returned fit with the oldest prediction
  task automatic check_fit(out_item_t got);
    out_item_t want;
    fits_o++;
    if (expected_fits.size() == 0) begin
      report_mismatch("unexpected result", got.slope, '0);
      return;
    end
    want = expected_fits.pop_front();
    pending_o = expected_fits.size();
    if (want.status == STATUS_DEGEN) degen_o++;
    if (want.status == STATUS_DROP) drop_o++;
    if (got.slope !== want.slope) report_mismatch("slope", got.slope, want.slope);
    if (got.intercept !== want.intercept)
      report_mismatch("intercept", got.intercept, want.intercept);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
  endtask

  // Check results before taking points so a stray result never meets a fresh prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_set();
      expected_fits.delete();
      mismatch_count_o = 0;
      pending_o = 0;
      fits_o = 0;
      degen_o = 0;
      drop_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_fit(out_item_i);
      if (in_valid_i && !in_stall_i) take_point(in_item_i);
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lslf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_POINTS  = 280;
  localparam int SETTLE_CYCLES = 100;

  typedef enum int {
    SHAPE_SCATTER,
    SHAPE_SAME_X,
    SHAPE_LINE,
    SHAPE_TINY,
    SHAPE_STEEP
  } set_shape_e;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int mismatches;
  int fits_pending;
  int fits_done;
  int degen_fits;
  int drop_fits;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int points_sent = 0;
  int cycle_count = 0;

  least_squares_line_fit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  lslf_fit_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_i      (out_item),
    .mismatch_count_o(mismatches),
    .pending_o       (fits_pending),
    .fits_o          (fits_done),
    .degen_o         (degen_fits),
    .drop_o          (drop_fits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Present one point after an optional gap; hold it until the transfer
  task automatic send_point(int x, int y, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item.point_x <= 16'(x);
    in_item.point_y <= 16'(y);
    in_item.last_point <= last;
    do @(posedge clk); while (in_stall);
    points_sent++;
    @(negedge clk);
  endtask

  // Send one set of points of the given shape, marking the final one
  task automatic send_set(int len, set_shape_e shape);
    int i;
    int xi;
    int yi;
    int x_base;
    int rise;
    int offs;
    x_base = rand_between(-32768, 32767);
    rise = rand_between(-8, 8);
    offs = rand_between(-4096, 4095);
    for (i = 0; i < len; i++) begin
      case (shape)
        SHAPE_SAME_X: begin
          xi = x_base;
          yi = $urandom;
        end
        SHAPE_LINE: begin
          xi = x_base / 4 + rand_between(-2048, 2047);
          yi = rise * xi / 4 + offs + rand_between(-8, 7);
        end
        SHAPE_TINY: begin
          xi = rand_between(-512, 511);
          yi = rand_between(-512, 511);
        end
        SHAPE_STEEP: begin
          xi = x_base + (i % 2);
          yi = $urandom;
        end
        default: begin
          xi = $urandom;
          yi = $urandom;
        end
      endcase
      send_point(xi, yi, i == len - 1);
    end
  endtask

  // Random sets, mostly short, until the point budget is spent
  task automatic random_sets(int budget);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) len = 1;
      else if (pick < 80) len = rand_between(2, 12);
      else len = rand_between(13, 48);
      send_set(len, set_shape_e'($urandom_range(SHAPE_STEEP)));
      sent += len;
    end
  endtask

  task automatic drain_fits();
    while (fits_pending != 0) @(negedge clk);
  endtask

  initial begin
    // Hold reset, then release on a falling edge
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: sender rarely idles, receiver stalls often
    send_idle_pct = 6;
    recv_idle_pct = 52;

    // Extremes of both coordinates, rising and falling
    send_point(-32768, -32768, 1'b0);
    send_point(32767, 32767, 1'b1);
    send_point(-32768, 32767, 1'b0);
    send_point(32767, -32768, 1'b1);
    // Degenerate: a single point, equal x, all zero
    send_point(1234, 77, 1'b1);
    send_point(100, 5, 1'b0);
    send_point(100, -7, 1'b0);
    send_point(100, 300, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(0, 0, 1'b1);
    // Slope saturation both ways, then intercept saturation
    send_point(0, -32768, 1'b0);
    send_point(1, 32767, 1'b1);
    send_point(0, 32767, 1'b0);
    send_point(1, -32768, 1'b1);
    send_point(32766, -32768, 1'b0);
    send_point(32767, 32767, 1'b1);
    // Exact unit slope through the origin, then a rounded fraction
    send_point(0, 0, 1'b0);
    send_point(256, 256, 1'b0);
    send_point(512, 512, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(3, 1, 1'b1);

    random_sets(PHASE_POINTS);
    drain_fits();

    // Phase two: sender idles often, receiver rarely stalls
    send_idle_pct = 52;
    recv_idle_pct = 6;
    random_sets(PHASE_POINTS);
    // Over capacity with scattered points: dropped points flagged
    send_set(MAX_POINTS + rand_between(1, 3), SHAPE_SCATTER);
    drain_fits();

    // Phase three: back to back in both directions
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sets(PHASE_POINTS);
    in_valid <= 1'b0;

    drain_fits();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d points, checked %0d fits (%0d degenerate, %0d with dropped points)",
             points_sent, fits_done, degen_fits, drop_fits);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ least_squares_line_fit.f @@
src/lslf_pkg.sv
src/lslf_mul.sv
src/lslf_div.sv
src/least_squares_line_fit.sv
src/lslf_checker.sv
sim/lslf_fit_checker.sv
sim/tb_top.sv
